FILE: sv/omca_pkg.sv
// Shared types, constants and saturating helpers for the online mean and
// covariance accumulator. No dependencies; every other file imports this one.
package omca_pkg;

   localparam int DIM      = 4;
   localparam int IDX_W    = 2;
   localparam int CNT_W    = 40;
   localparam int W_W      = 17;
   localparam int DIV_W    = 57;
   localparam int DIV_CW   = 6;
   localparam int NCOL     = 4;

   localparam logic [W_W-1:0]   ONE_W   = 17'd65536;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic STAT_OK    = 1'b0;
   localparam logic STAT_EMPTY = 1'b1;

   localparam logic signed [63:0] MAX32 = 64'sd2147483647;
   localparam logic signed [63:0] MIN32 = -64'sd2147483648;
   localparam logic signed [63:0] MAX64 = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] MIN64 = {1'b1, {63{1'b0}}};

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_READ   = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      L_IDLE,
      L_DIV_Q,
      L_DIV_C,
      L_MUL_A,
      L_MUL_B,
      L_MUL_T1,
      L_MUL_T2
   } lane_state_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_LAUNCH,
      T_PH1,
      T_PH2,
      T_RESP,
      T_READ
   } top_state_type;

   typedef logic signed [63:0] word_type;
   typedef logic [DIM-1:0][63:0] word_vec_type;

   typedef struct packed {
      logic             start1;
      logic             start2;
      logic             clear;
      logic             remove;
      logic [W_W-1:0]   w;
      logic [CNT_W-1:0] n;
      logic [CNT_W-1:0] divisor;
   } lane_ctl_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > MAX32) begin
         r = 32'h7FFFFFFF;
      end else if (v < MIN32) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      logic signed [63:0] r;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         r = s[64] ? MIN64 : MAX64;
      end else begin
         r = s[63:0];
      end
      return r;
   endfunction

   function automatic logic signed [63:0] neg_sat64(input logic signed [63:0] t);
      logic signed [63:0] r;
      if (t == MIN64) begin
         r = MAX64;
      end else begin
         r = -t;
      end
      return r;
   endfunction

endpackage

FILE: sv/online_mean_covariance_accumulator.sv
// Top level of the weighted online mean and covariance accumulator: request
// decode, count register, lane control, read-out merge and result register.
// Uses omca_lane; depends on omca_pkg.
//
//   channel   direction  payload
//   req_*     in         tuser: req_type; tdata: x0..x3, weight
//   rsp_*     out        tuser: status; tdata: row, mean, count, 4 columns; tlast
//
// One request at a time. An add runs one divide and then two multiplies in
// every lane, a remove two divides and then one multiply; then eight multiplies
// run in the last lane, which owns the longest column.
// Clear, rejected removes and zero-weight adds bypass the lanes; a read-out
// gives DIM items back to back unless the result channel stalls. Reset is
// synchronous and empties the store. A stalled result holds in the output
// register; the next request is taken while the final result of the previous
// one waits there.
module online_mean_covariance_accumulator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [151:0] req_tdata,   // x0, x1, x2, x3, weight, zero pad
   input  logic [1:0]   req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [335:0] rsp_tdata,   // row_index, mean_value, total_weight,
                                     // prod_col0..prod_col3, zero pad
   output logic [0:0]   rsp_tuser,   // status
   output logic         rsp_tlast    // last_row
);
   import omca_pkg::*;

   top_state_type    state_ff, state_in;
   logic             remove_ff;
   logic [W_W-1:0]   w_ff;
   logic [CNT_W-1:0] n_ff, div_ff;
   logic [31:0]      x_ff [DIM];
   logic             status_ff;
   logic [IDX_W-1:0] row_ff;

   logic             rsp_valid_ff;
   logic [IDX_W-1:0] rsp_row_ff;
   logic [31:0]      rsp_mean_ff;
   logic [CNT_W-1:0] rsp_total_ff;
   logic [63:0]      rsp_col_ff [NCOL];
   logic             rsp_status_ff, rsp_last_ff;

   logic             accept, out_free, all_idle;
   logic             load_ctl, do_clear, load_single, load_row, update_count;
   logic             status_in;
   logic [W_W-1:0]   weight, wclamp;
   logic [CNT_W:0]   nsum;
   logic [CNT_W-1:0] nn, n1;
   req_kind_type     kind;

   lane_ctl_type     ctl;
   logic [DIM-1:0]   lane_busy;
   word_vec_type     a_vec, b_vec;
   word_vec_type     lane_p [DIM];
   logic [31:0]      lane_mean [DIM];
   logic [63:0]      col_sel [NCOL];

   assign kind     = req_kind_type'(req_tuser);
   assign weight   = req_tdata[128 +: W_W];
   assign wclamp   = (weight > ONE_W) ? ONE_W : weight;
   assign nsum     = {1'b0, n_ff} + {{(CNT_W+1-W_W){1'b0}}, wclamp};
   assign nn       = nsum[CNT_W] ? CNT_MAX : nsum[CNT_W-1:0];
   assign n1       = n_ff - {{(CNT_W-W_W){1'b0}}, ONE_W};
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign all_idle = (lane_busy == '0);
   assign accept   = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      req_tready   = (state_ff == T_IDLE);
      load_ctl     = 1'b0;
      do_clear     = 1'b0;
      load_single  = 1'b0;
      load_row     = 1'b0;
      update_count = 1'b0;
      status_in    = STAT_OK;
      ctl.start1   = (state_ff == T_LAUNCH);
      ctl.start2   = 1'b0;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               load_ctl = 1'b1;
               case (kind)
                  REQ_ADD: begin
                     state_in = (wclamp == '0) ? T_RESP : T_LAUNCH;
                  end
                  REQ_REMOVE: begin
                     if (n_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = T_RESP;
                     end else if (n_ff <= {{(CNT_W-W_W){1'b0}}, ONE_W}) begin
                        do_clear = 1'b1;
                        state_in = T_RESP;
                     end else begin
                        state_in = T_LAUNCH;
                     end
                  end
                  REQ_READ: begin
                     state_in = T_READ;
                  end
                  REQ_CLEAR: begin
                     do_clear = 1'b1;
                     state_in = T_RESP;
                  end
                  default: begin
                     state_in = T_IDLE;
                  end
               endcase
            end
         end
         T_LAUNCH: begin
            state_in = T_PH1;
         end
         T_PH1: begin
            if (all_idle) begin
               ctl.start2 = 1'b1;
               state_in   = T_PH2;
            end
         end
         T_PH2: begin
            if (all_idle) begin
               update_count = 1'b1;
               state_in     = T_RESP;
            end
         end
         T_RESP: begin
            if (out_free) begin
               load_single = 1'b1;
               state_in    = T_IDLE;
            end
         end
         T_READ: begin
            if (out_free) begin
               load_row = 1'b1;
               if (row_ff == IDX_W'(DIM - 1)) begin
                  state_in = T_IDLE;
               end
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
      ctl.clear   = do_clear;
      ctl.remove  = remove_ff;
      ctl.w       = w_ff;
      ctl.n       = n_ff;
      ctl.divisor = div_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (do_clear) begin
            n_ff <= '0;
         end else if (update_count) begin
            n_ff <= div_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_ctl) begin
         remove_ff <= (kind == REQ_REMOVE);
         w_ff      <= wclamp;
         div_ff    <= (kind == REQ_REMOVE) ? n1 : nn;
         status_ff <= status_in;
         row_ff    <= '0;
         for (int j = 0; j < DIM; j++) begin
            x_ff[j] <= req_tdata[32*j +: 32];
         end
      end else if (load_row) begin
         row_ff <= row_ff + IDX_W'(1);
      end
   end

   for (genvar g = 0; g < DIM; g++) begin : g_lane
      omca_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .lane_id  (IDX_W'(g)),
         .ctl      (ctl),
         .x        (x_ff[g]),
         .a_all    (a_vec),
         .b_all    (b_vec),
         .busy     (lane_busy[g]),
         .a_out    (a_vec[g]),
         .b_out    (b_vec[g]),
         .mean_out (lane_mean[g]),
         .p_out    (lane_p[g])
      );
   end

   // The matrix is stored by columns of the upper triangle; mirror on read.
   always_comb begin
      for (int c = 0; c < NCOL; c++) begin
         col_sel[c] = '0;
         if (c < DIM) begin
            if (row_ff > IDX_W'(c)) begin
               col_sel[c] = lane_p[row_ff][c];
            end else begin
               col_sel[c] = lane_p[c][row_ff];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_single || load_row) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_single) begin
         rsp_row_ff    <= '0;
         rsp_mean_ff   <= '0;
         rsp_total_ff  <= '0;
         rsp_status_ff <= status_ff;
         rsp_last_ff   <= 1'b1;
         for (int c = 0; c < NCOL; c++) begin
            rsp_col_ff[c] <= '0;
         end
      end else if (load_row) begin
         rsp_row_ff    <= row_ff;
         rsp_mean_ff   <= lane_mean[row_ff];
         rsp_total_ff  <= n_ff;
         rsp_status_ff <= STAT_OK;
         rsp_last_ff   <= (row_ff == IDX_W'(DIM - 1));
         for (int c = 0; c < NCOL; c++) begin
            rsp_col_ff[c] <= col_sel[c];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_col_ff[3], rsp_col_ff[2], rsp_col_ff[1], rsp_col_ff[0],
                        rsp_total_ff, rsp_mean_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: sv/omca_mul.sv
// Sign-magnitude 64x64 multiplier built from four 32x32 partial products,
// with an optional 16-bit right shift and saturation to signed 64 bits.
// Depends on omca_pkg.
module omca_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  omca_pkg::word_type a,
   input  omca_pkg::word_type b,
   input  logic              shift16,
   output logic              done,
   output omca_pkg::word_type result
);
   import omca_pkg::*;

   logic [63:0]  ua_ff, ub_ff;
   logic         neg_ff, s_ff;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   cnt_ff;
   logic         busy_ff, fin_ff, done_ff;
   word_type     res_ff, res_in;

   logic [31:0]  a_half, b_half;
   logic [63:0]  part;
   logic [1:0]   sum2;
   logic [6:0]   shamt;
   logic [127:0] sh;
   logic [63:0]  hi, lo;

   always_comb begin
      a_half = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      b_half = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      part   = a_half * b_half;
      sum2   = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
      shamt  = {sum2, 5'b0};
      acc_in = acc_ff + ({64'b0, part} << shamt);

      sh = s_ff ? (acc_ff >> 16) : acc_ff;
      hi = sh[127:64];
      lo = sh[63:0];
      if (neg_ff) begin
         if (hi != 64'd0 || lo > 64'h8000000000000000) begin
            res_in = MIN64;
         end else begin
            res_in = -$signed(lo);
         end
      end else begin
         if (hi != 64'd0 || lo > 64'h7FFFFFFFFFFFFFFF) begin
            res_in = MAX64;
         end else begin
            res_in = $signed(lo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff && !fin_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff && !fin_ff) begin
         ua_ff  <= a[63] ? 64'(-a) : 64'(a);
         ub_ff  <= b[63] ? 64'(-b) : 64'(b);
         neg_ff <= a[63] ^ b[63];
         s_ff   <= shift16;
         acc_ff <= 128'd0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
      end
      if (fin_ff) begin
         res_ff <= res_in;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

FILE: sv/omca_div.sv
// Restoring unsigned divider, one quotient bit per cycle, truncating.
// Depends on omca_pkg for the operand widths.
module omca_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [omca_pkg::DIV_W-1:0] dividend,
   input  logic [omca_pkg::CNT_W-1:0] divisor,
   output logic                       done,
   output logic [omca_pkg::DIV_W-1:0] quotient
);
   import omca_pkg::*;

   logic [DIV_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff, den_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic              busy_ff, done_ff;

   logic [CNT_W:0]    trial, diff;
   logic              ge;
   logic [CNT_W-1:0]  rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CW'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIV_CW'(1);
            if (cnt_ff == DIV_CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/omca_lane.sv
// One accumulator lane: owns the mean of one dimension and one column of the
// upper-triangle product matrix. Uses omca_div and omca_mul; depends on omca_pkg.
module omca_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [omca_pkg::IDX_W-1:0]    lane_id,
   input  omca_pkg::lane_ctl_type        ctl,
   input  logic signed [31:0]            x,
   input  omca_pkg::word_vec_type        a_all,
   input  omca_pkg::word_vec_type        b_all,
   output logic                          busy,
   output omca_pkg::word_type            a_out,
   output omca_pkg::word_type            b_out,
   output logic [31:0]                   mean_out,
   output omca_pkg::word_vec_type        p_out
);
   import omca_pkg::*;

   lane_state_type   state_ff, state_in;
   logic [31:0]      mean_ff;
   word_type         u_ff, e_ff, a_ff, b_ff, t1_ff;
   word_vec_type     p_ff;
   logic             neg_ff;
   logic [IDX_W-1:0] i_ff;

   logic             div_start, div_done;
   logic [DIV_W-1:0] div_dividend, div_quot;
   logic [CNT_W-1:0] div_divisor;
   logic             mul_start, mul_done, mul_s;
   word_type         mul_a, mul_b, mul_res;

   logic signed [32:0] diff;
   logic [32:0]        dmag;
   logic [W_W-1:0]     mult;
   logic [49:0]        prod;
   word_type           q64, q, mean_sum, e_new, t_sum, t_fix;
   logic [31:0]        mean_new;

   always_comb begin
      if (ctl.remove) begin
         diff = {mean_ff[31], mean_ff} - {x[31], x};
      end else begin
         diff = {x[31], x} - {mean_ff[31], mean_ff};
      end
      dmag     = diff[32] ? 33'(-diff) : 33'(diff);
      mult     = ctl.remove ? ONE_W : ctl.w;
      prod     = dmag * mult;
      q64      = {{(64-DIV_W){1'b0}}, div_quot};
      q        = neg_ff ? -q64 : q64;
      mean_sum = {{32{mean_ff[31]}}, mean_ff} + q;
      mean_new = sat32(mean_sum);
      e_new    = {{32{x[31]}}, x} - {{32{mean_new[31]}}, mean_new};
      t_sum    = add_sat64(t1_ff, mul_res);
      t_fix    = ctl.remove ? neg_sat64(t_sum) : t_sum;
   end

   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_dividend = {{(DIV_W-50){1'b0}}, prod};
      div_divisor  = ctl.divisor;
      mul_start    = 1'b0;
      mul_a        = a_all[0];
      mul_b        = u_ff;
      mul_s        = 1'b0;
      case (state_ff)
         L_IDLE: begin
            if (ctl.start1) begin
               div_start = 1'b1;
               state_in  = L_DIV_Q;
            end else if (ctl.start2) begin
               mul_start = 1'b1;
               state_in  = L_MUL_T1;
            end
         end
         L_DIV_Q: begin
            if (div_done) begin
               if (ctl.remove) begin
                  div_start    = 1'b1;
                  div_dividend = {1'b0, ctl.divisor, 16'b0};
                  div_divisor  = ctl.n;
                  state_in     = L_DIV_C;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = {24'b0, ctl.n};
                  mul_b     = q;
                  mul_s     = 1'b1;
                  state_in  = L_MUL_A;
               end
            end
         end
         L_DIV_C: begin
            if (div_done) begin
               mul_start = 1'b1;
               mul_a     = q64;
               mul_b     = e_ff;
               mul_s     = 1'b1;
               state_in  = L_MUL_A;
            end
         end
         L_MUL_A: begin
            if (mul_done) begin
               if (ctl.remove) begin
                  state_in = L_IDLE;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = {47'b0, ctl.w};
                  mul_b     = e_ff;
                  mul_s     = 1'b1;
                  state_in  = L_MUL_B;
               end
            end
         end
         L_MUL_B: begin
            if (mul_done) begin
               state_in = L_IDLE;
            end
         end
         L_MUL_T1: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = b_all[i_ff];
               mul_b     = e_ff;
               state_in  = L_MUL_T2;
            end
         end
         L_MUL_T2: begin
            if (mul_done) begin
               if (i_ff == lane_id) begin
                  state_in = L_IDLE;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = a_all[i_ff + IDX_W'(1)];
                  state_in  = L_MUL_T1;
               end
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         mean_ff <= '0;
         p_ff    <= '0;
      end else begin
         if (state_ff == L_DIV_Q && div_done) begin
            mean_ff <= mean_new;
         end
         if (state_ff == L_MUL_T2 && mul_done) begin
            p_ff[i_ff] <= add_sat64(p_ff[i_ff], t_fix);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == L_IDLE && ctl.start1) begin
         neg_ff <= diff[32];
      end
      if (state_ff == L_IDLE && ctl.start2) begin
         i_ff <= '0;
      end
      if (state_ff == L_DIV_Q && div_done) begin
         e_ff <= e_new;
         u_ff <= ctl.remove ? e_new : q;
      end
      if (state_ff == L_MUL_A && mul_done) begin
         a_ff <= mul_res;
         if (ctl.remove) begin
            b_ff <= '0;
         end
      end
      if (state_ff == L_MUL_B && mul_done) begin
         b_ff <= mul_res;
      end
      if (state_ff == L_MUL_T1 && mul_done) begin
         t1_ff <= mul_res;
      end
      if (state_ff == L_MUL_T2 && mul_done) begin
         i_ff <= i_ff + IDX_W'(1);
      end
   end

   omca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   omca_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .shift16 (mul_s),
      .done    (mul_done),
      .result  (mul_res)
   );

   assign busy     = (state_ff != L_IDLE);
   assign a_out    = a_ff;
   assign b_out    = b_ff;
   assign mean_out = mean_ff;
   assign p_out    = p_ff;

endmodule

FILE: tb/sv/omca_checker.sv
`timescale 1ns / 100ps
// Checker for the online mean and covariance accumulator: watches both item
// channels, keeps its own copy of the store, predicts every result item and
// compares it. Depends on omca_pkg.
module omca_checker
   import omca_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [151:0] req_tdata,   // x0, x1, x2, x3, weight, zero pad
   input  logic [1:0]   req_tuser,   // req_type
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [335:0] rsp_tdata,   // row_index, mean_value, total_weight,
                                     // prod_col0..prod_col3, zero pad
   input  logic [0:0]   rsp_tuser,   // status
   input  logic         rsp_tlast,   // last_row
   output int           fail_count,
   output int           pending_rows
);

   typedef struct {
      logic [1:0]         row;
      logic signed [31:0] mean;
      logic [39:0]        count;
      logic signed [63:0] col [4];
      logic               status;
      logic               last;
   } row_type;

   row_type            expected_rows [$];
   logic [39:0]        acc_count;
   logic signed [31:0] acc_mean [DIM];
   // Upper triangle only: entry [i][j] is valid for i <= j.
   logic signed [63:0] acc_prod [DIM][DIM];

   // Exact product, magnitude shifted toward zero, saturated to 64 bits.
   function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int sh);
      logic         neg;
      logic [127:0] ua, ub, m;
      neg = a[63] ^ b[63];
      ua = {64'd0, (a[63] ? (~a + 64'd1) : a)};
      ub = {64'd0, (b[63] ? (~b + 64'd1) : b)};
      m = (ua * ub) >> sh;
      if (neg) begin
         if (m > 128'h8000_0000_0000_0000) return MIN64;
         return -m[63:0];
      end
      if (m > 128'h7FFF_FFFF_FFFF_FFFF) return MAX64;
      return m[63:0];
   endfunction

   function automatic logic signed [63:0] sum_clamped(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return MAX64;
      if (s < -65'sh0_8000_0000_0000_0000) return MIN64;
      return s[63:0];
   endfunction

   function automatic logic signed [31:0] clamp_mean(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   task automatic empty_store();
      acc_count = '0;
      for (int i = 0; i < DIM; i++) begin
         acc_mean[i] = '0;
         for (int j = 0; j < DIM; j++) acc_prod[i][j] = '0;
      end
   endtask

   task automatic fold_sample(input logic signed [63:0] y [DIM],
                              input logic signed [63:0] w);
      logic signed [63:0] n, nn, a, b, t;
      logic signed [63:0] step [DIM];
      logic signed [63:0] e [DIM];
      n = {24'd0, acc_count};
      nn = n + w;
      if (w == 0) return;
      if (nn > {24'd0, CNT_MAX}) nn = {24'd0, CNT_MAX};
      for (int i = 0; i < DIM; i++) begin
         step[i] = ((y[i] - acc_mean[i]) * w) / nn;
         acc_mean[i] = clamp_mean(acc_mean[i] + step[i]);
         e[i] = y[i] - acc_mean[i];
      end
      for (int i = 0; i < DIM; i++) begin
         a = scaled_product(n, step[i], 16);
         b = scaled_product(w, e[i], 16);
         for (int j = i; j < DIM; j++) begin
            t = sum_clamped(scaled_product(a, step[j], 0), scaled_product(b, e[j], 0));
            acc_prod[i][j] = sum_clamped(acc_prod[i][j], t);
         end
      end
      acc_count = nn[39:0];
   endtask

   task automatic unfold_sample(input logic signed [63:0] y [DIM]);
      logic signed [63:0] n, n1, c, a, t;
      logic signed [63:0] e [DIM];
      n = {24'd0, acc_count};
      n1 = n - 64'sd65536;
      if (n <= 64'sd65536) begin
         empty_store();
         return;
      end
      for (int i = 0; i < DIM; i++) begin
         acc_mean[i] = clamp_mean(acc_mean[i] + ((acc_mean[i] - y[i]) * 64'sd65536) / n1);
         e[i] = y[i] - acc_mean[i];
      end
      c = (n1 * 64'sd65536) / n;
      for (int i = 0; i < DIM; i++) begin
         a = scaled_product(c, e[i], 16);
         for (int j = i; j < DIM; j++) begin
            t = scaled_product(a, e[j], 0);
            acc_prod[i][j] = sum_clamped(acc_prod[i][j], (t == MIN64) ? MAX64 : -t);
         end
      end
      acc_count = n1[39:0];
   endtask

   task automatic apply_request();
      req_kind_type       kind;
      logic signed [63:0] y [DIM];
      logic signed [63:0] w;
      row_type            r;
      kind = req_kind_type'(req_tuser);
      for (int i = 0; i < DIM; i++) y[i] = $signed(req_tdata[32*i +: 32]);
      w = {47'd0, req_tdata[144:128]};
      if (w > 64'sd65536) w = 64'sd65536;
      r.row = '0;
      r.mean = '0;
      r.count = '0;
      for (int j = 0; j < 4; j++) r.col[j] = '0;
      r.status = STAT_OK;
      r.last = 1'b1;
      case (kind)
         REQ_READ: begin
            for (int i = 0; i < DIM; i++) begin
               r.row = i;
               r.mean = acc_mean[i];
               r.count = acc_count;
               for (int j = 0; j < DIM; j++)
                  r.col[j] = (i <= j) ? acc_prod[i][j] : acc_prod[j][i];
               r.last = (i == DIM - 1);
               expected_rows = {expected_rows, r};
            end
         end
         REQ_ADD: begin
            fold_sample(y, w);
            expected_rows = {expected_rows, r};
         end
         REQ_REMOVE: begin
            if (acc_count == 0) r.status = STAT_EMPTY;
            else unfold_sample(y);
            expected_rows = {expected_rows, r};
         end
         default: begin
            empty_store();
            expected_rows = {expected_rows, r};
         end
      endcase
   endtask

   task automatic check_row();
      row_type exp_r;
      if (expected_rows.size() == 0) begin
         $error("result item with no expectation waiting");
         fail_count++;
         return;
      end
      exp_r = expected_rows.pop_front();
      if (rsp_tdata[1:0] !== exp_r.row) begin
         $error("row_index: expected %0d, actual %0d", exp_r.row, rsp_tdata[1:0]);
         fail_count++;
      end
      if (rsp_tdata[33:2] !== exp_r.mean) begin
         $error("mean_value: expected %0d, actual %0d", exp_r.mean, $signed(rsp_tdata[33:2]));
         fail_count++;
      end
      if (rsp_tdata[73:34] !== exp_r.count) begin
         $error("total_weight: expected %0d, actual %0d", exp_r.count, rsp_tdata[73:34]);
         fail_count++;
      end
      for (int j = 0; j < 4; j++) begin
         if (rsp_tdata[74 + 64*j +: 64] !== exp_r.col[j]) begin
            $error("prod_col%0d: expected %0d, actual %0d", j, exp_r.col[j],
                   $signed(rsp_tdata[74 + 64*j +: 64]));
            fail_count++;
         end
      end
      if (rsp_tuser[0] !== exp_r.status) begin
         $error("status: expected %0d, actual %0d", exp_r.status, rsp_tuser[0]);
         fail_count++;
      end
      if (rsp_tlast !== exp_r.last) begin
         $error("last_row: expected %0d, actual %0d", exp_r.last, rsp_tlast);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_rows = 0;
      empty_store();
   end

   always @(posedge clock) begin
      if (reset) begin
         empty_store();
      end else begin
         if (req_tvalid && req_tready) apply_request();
         if (rsp_tvalid && rsp_tready) check_row();
      end
      pending_rows = expected_rows.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the accumulator testbench: clock, reset, request stimulus, random
// result back-pressure and the verdict. Uses omca_checker and omca_pkg.
module tb_top;
   import omca_pkg::*;

   localparam int RANDOM_ITEMS = 390;
   localparam int CYCLE_LIMIT  = 1000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [335:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         rsp_tlast;
   int           fail_count;
   int           pending_rows;
   int           cycles = 0;
   int           ready_hold = 0;
   logic         no_gaps = 1'b0;

   always #2 clock = ~clock;

   online_mean_covariance_accumulator i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   omca_checker i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .fail_count(fail_count), .pending_rows(pending_rows)
   );

   // Mostly short gaps, now and then a long one; none during a burst stretch.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] sample_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom();
         default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      endcase
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         ready_hold <= gap_length();
      end
   end

   // Called right after a rising edge; returns right after the edge that took the item.
   task automatic send_item(input req_kind_type kind, input logic [31:0] a,
                            input logic [31:0] b, input logic [31:0] c,
                            input logic [31:0] d, input logic [16:0] w);
      req_tuser <= kind;
      req_tdata <= {7'd0, w, d, c, b, a};
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic idle_gap();
      int g;
      g = gap_length();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_random();
      int           r;
      logic [16:0]  w;
      req_kind_type kind;
      r = $urandom_range(0, 99);
      if (r < 55) kind = REQ_ADD;
      else if (r < 72) kind = REQ_REMOVE;
      else if (r < 94) kind = REQ_READ;
      else kind = REQ_CLEAR;
      case ($urandom_range(0, 7))
         0: w = $urandom_range(0, 17'h1FFFF);
         1: w = 17'd0;
         2, 3: w = ONE_W;
         default: w = $urandom_range(1, 65536);
      endcase
      send_item(kind, sample_value(), sample_value(), sample_value(), sample_value(), w);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(REQ_CLEAR, '0, '0, '0, '0, '0);
      send_item(REQ_REMOVE, '0, '0, '0, '0, ONE_W);      // remove on an empty store
      send_item(REQ_READ, '0, '0, '0, '0, '0);
      send_item(REQ_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, ONE_W);
      idle_gap();
      send_item(REQ_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, '0, ONE_W);
      send_item(REQ_READ, '0, '0, '0, '0, '0);
      send_item(REQ_ADD, 32'h1234_5678, 32'hFFFF_0000, '0, '1, 17'd0);  // zero weight
      send_item(REQ_ADD, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, '1, 17'h1FFFF);
      send_item(REQ_ADD, 32'h0003_0000, 32'h0001_0000, 32'h8000_0000, '0, 17'd1);
      send_item(REQ_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 32'h4000_0000, 32'h7FFF_FFFF, 17'd32768);
      send_item(REQ_READ, '0, '0, '0, '0, '0);
      send_item(REQ_REMOVE, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, '1, '0);
      send_item(REQ_READ, '0, '0, '0, '0, '0);
      send_item(REQ_REMOVE, 32'h7FFF_FFFF, '0, '0, 32'h8000_0000, '0);
      send_item(REQ_REMOVE, '0, '0, '0, '0, '0);
      send_item(REQ_REMOVE, '0, '0, '0, '0, '0);
      send_item(REQ_READ, '0, '0, '0, '0, '0);
      // A remove with at most one observation stored empties the store.
      send_item(REQ_ADD, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 17'd40000);
      send_item(REQ_REMOVE, '0, '0, '0, '0, '0);
      send_item(REQ_READ, '0, '0, '0, '0, '0);
      send_item(REQ_REMOVE, '0, '0, '0, '0, '0);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         if (k == RANDOM_ITEMS / 2) begin
            // Let the block drain completely before going on.
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_rows != 0) @(posedge clock);
         end
         idle_gap();
         send_random();
      end
      req_tvalid <= 1'b0;

      // The checker counts the last item at the edge that took it; wait for the next edge before looking.
      @(posedge clock);
      while (pending_rows != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_rows == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/omca_pkg.sv
sv/omca_mul.sv
sv/omca_div.sv
sv/omca_lane.sv
sv/online_mean_covariance_accumulator.sv
tb/sv/omca_checker.sv
tb/sv/tb_top.sv
